### design/u8u16_pkg.sv
`default_nettype none
package u8u16_pkg;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_LIMIT   = 2'd2;

  localparam logic [7:0]  LEAD2_LOW  = 8'hc2;
  localparam logic [7:0]  LEAD4_HIGH = 8'hf4;
  localparam logic [20:0] MIN3       = 21'h000800;
  localparam logic [20:0] MIN4       = 21'h010000;
  localparam logic [20:0] SURR_FIRST = 21'h00d800;
  localparam logic [20:0] SURR_LAST  = 21'h00dfff;
  localparam logic [20:0] CP_MAX     = 21'h10ffff;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

  localparam logic [15:0] MAX_CP_RESET = 16'd4096;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_of_run;
    logic        end_of_text;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } dec_t;

endpackage
`default_nettype wire

### design/u8u16_decode.sv
`default_nettype none
module u8u16_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [7:0]        text_byte,
  input  wire logic [15:0]       max_cp,
  output u8u16_pkg::dec_t        dec
);

  logic [20:0] acc_r, acc_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [1:0]  seq_r, seq_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic [1:0]  err_r, err_nxt;

  logic [20:0] cont_acc;
  logic [20:0] fin_cp;
  logic [1:0]  fin_len;
  logic        fin_go;
  logic        bad_cp;
  logic        over;
  logic [20:0] supp;

  assign cont_acc = {acc_r[14:0], text_byte[5:0]};
  assign fin_cp   = (rem_r == 2'd0) ? {13'd0, text_byte} : cont_acc;
  assign fin_len  = (rem_r == 2'd0) ? 2'd0 : seq_r;
  assign supp     = fin_cp - u8u16_pkg::MIN4;

  assign bad_cp = (fin_len == 2'd2 && fin_cp < u8u16_pkg::MIN3) ||
                  (fin_len == 2'd3 && fin_cp < u8u16_pkg::MIN4) ||
                  (fin_cp >= u8u16_pkg::SURR_FIRST && fin_cp <= u8u16_pkg::SURR_LAST) ||
                  (fin_cp > u8u16_pkg::CP_MAX);
  assign over   = ({1'b0, cnt_r} + 18'd1) > {2'b00, max_cp};

  always_comb begin
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    seq_nxt = seq_r;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    fin_go  = 1'b0;
    dec     = '0;

    if (text_byte == 8'd0) begin
      dec.num            = 2'd1;
      dec.r0.last_of_run = 1'b1;
      dec.r0.end_of_text = 1'b1;
      dec.r0.status      = (err_r == u8u16_pkg::ERR_NONE && rem_r != 2'd0) ?
                           u8u16_pkg::ERR_INVALID : err_r;
      acc_nxt = '0;
      rem_nxt = '0;
      seq_nxt = '0;
      cnt_nxt = '0;
      err_nxt = u8u16_pkg::ERR_NONE;
    end else if (err_r != u8u16_pkg::ERR_NONE) begin
      dec.num = 2'd0;
    end else if (rem_r == 2'd0) begin
      if (text_byte[7] == 1'b0) begin
        fin_go = 1'b1;
      end else if (text_byte >= u8u16_pkg::LEAD2_LOW && text_byte <= 8'hdf) begin
        acc_nxt = {16'd0, text_byte[4:0]};
        seq_nxt = 2'd1;
        rem_nxt = 2'd1;
      end else if (text_byte >= 8'he0 && text_byte <= 8'hef) begin
        acc_nxt = {17'd0, text_byte[3:0]};
        seq_nxt = 2'd2;
        rem_nxt = 2'd2;
      end else if (text_byte >= 8'hf0 && text_byte <= u8u16_pkg::LEAD4_HIGH) begin
        acc_nxt = {18'd0, text_byte[2:0]};
        seq_nxt = 2'd3;
        rem_nxt = 2'd3;
      end else begin
        err_nxt = u8u16_pkg::ERR_INVALID;
      end
    end else if (text_byte[7:6] != 2'b10) begin
      err_nxt = u8u16_pkg::ERR_INVALID;
      rem_nxt = 2'd0;
    end else begin
      acc_nxt = cont_acc;
      rem_nxt = rem_r - 2'd1;
      fin_go  = (rem_r == 2'd1);
    end

    if (fin_go) begin
      if (bad_cp) begin
        err_nxt = u8u16_pkg::ERR_INVALID;
      end else if (over) begin
        err_nxt = u8u16_pkg::ERR_LIMIT;
      end else begin
        cnt_nxt = cnt_r + 17'd1;
        if (fin_cp > 21'h00ffff) begin
          dec.num            = 2'd2;
          dec.r0.code_unit   = {u8u16_pkg::HI_SURR_TAG, supp[19:10]};
          dec.r1.code_unit   = {u8u16_pkg::LO_SURR_TAG, supp[9:0]};
          dec.r1.last_of_run = 1'b1;
        end else begin
          dec.num            = 2'd1;
          dec.r0.code_unit   = fin_cp[15:0];
          dec.r0.last_of_run = 1'b1;
        end
      end
    end

    if (!take) begin
      dec.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= '0;
      seq_r <= '0;
      cnt_r <= '0;
      err_r <= u8u16_pkg::ERR_NONE;
    end else if (take) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      seq_r <= seq_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

endmodule
`default_nettype wire

### design/u8u16_outq.sv
`default_nettype none
module u8u16_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire u8u16_pkg::dec_t  dec,
  input  wire logic             pop,
  output logic                  head_valid,
  output u8u16_pkg::res_t       head,
  output logic                  no_room
);

  u8u16_pkg::res_t ent_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic [1:0] wp_inc;

  assign head_valid = (cnt_r != 3'd0);
  assign head       = ent_r[rp_r];
  assign no_room    = (cnt_r > 3'd2);
  assign wp_inc     = wp_r + 2'd1;

  always_ff @(posedge clk) begin
    if (dec.num != 2'd0) begin
      ent_r[wp_r] <= dec.r0;
    end
    if (dec.num == 2'd2) begin
      ent_r[wp_inc] <= dec.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + dec.num;
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, dec.num} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

### design/utf8_to_utf16_decoder.sv
`default_nettype none
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall  | in_text_byte[7:0]
// out_     | output    | out_valid/out_stall| out_code_unit, out_last_of_run,
//          |           |                    | out_end_of_text, out_status
// cfg      | APB       | psel/penable/pready| max_codepoints at address 0
//
// A byte is decoded in the cycle it is accepted; its units are registered in
// the result queue and leave on out_ from its head. Up to one unit leaves per
// cycle while out_stall is low; a supplementary codepoint's surrogate pair
// shares one port. A four-entry result queue separates the sides; in_stall
// rises when it cannot take two more units. Synchronous reset restores
// max_codepoints to 4096 and starts a new text.
module utf8_to_utf16_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_code_unit,
  output logic             out_last_of_run,
  output logic             out_end_of_text,
  output logic [1:0]       out_status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0]     max_cp_r;
  logic            take;
  logic            pop;
  u8u16_pkg::dec_t dec;
  u8u16_pkg::res_t head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, max_cp_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cp_r <= u8u16_pkg::MAX_CP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      max_cp_r <= pwdata[15:0];
    end
  end

  assign take = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  u8u16_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .text_byte (in_text_byte),
    .max_cp    (max_cp_r),
    .dec       (dec)
  );

  u8u16_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec        (dec),
    .pop        (pop),
    .head_valid (out_valid),
    .head       (head),
    .no_room    (in_stall)
  );

  assign out_code_unit   = head.code_unit;
  assign out_last_of_run = head.last_of_run;
  assign out_end_of_text = head.end_of_text;
  assign out_status      = head.status;

  a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with empty queue");

  a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_text) |-> (out_last_of_run && out_code_unit == 16'd0))
    else $error("terminator malformed");

  a_status_only_term: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_text) |-> (out_status == u8u16_pkg::ERR_NONE))
    else $error("status on a data unit");

  a_high_surr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_text && out_code_unit[15:10] == u8u16_pkg::HI_SURR_TAG)
    |-> !out_last_of_run) else $error("high surrogate closes a run");

endmodule
`default_nettype wire
